### src/alc_pkg.sv
// ----------------------------------------------------------------------------
// Ambient light lux conversion package
// Result status codes, register indexes and the divisor tables of the
// conversion pipeline; its checker imports the status codes.
// ----------------------------------------------------------------------------
package alc_pkg;

  typedef enum logic [1:0] {
    ST_BUS_ERR  = 2'd0,
    ST_NO_DATA  = 2'd1,
    ST_NEW_LUX  = 2'd2
  } lux_status_e;

  typedef enum logic {
    REG_RESOLUTION = 1'b0,
    REG_GAIN       = 1'b1
  } reg_idx_e;

  localparam int unsigned CodeW     = 3;
  localparam int unsigned CountW    = 20;
  localparam int unsigned NumW      = 26;
  localparam int unsigned DenW      = 13;
  localparam int unsigned RecipW    = 32;
  localparam int unsigned QuotW     = 22;
  localparam int unsigned RemW      = 14;
  localparam int unsigned LuxW      = 16;
  localparam logic [CodeW-1:0] NumCodes     = 3'd5;
  localparam logic [CodeW-1:0] ResResetCode = 3'd0;
  localparam logic [CodeW-1:0] GainResetCode = 3'd4;
  localparam int unsigned ReadyBit  = 3;

  typedef logic [DenW-1:0]   den_t;
  typedef logic [RecipW-1:0] recip_t;

  // Divisor is gain factor times conversion time in ms.
  function automatic den_t lux_den(input logic [CodeW-1:0] res,
                                   input logic [CodeW-1:0] gain);
    logic [DenW-1:0] ms;
    logic [DenW-1:0] d;
    case (res)
      3'd0:    ms = 13'd400;
      3'd1:    ms = 13'd200;
      3'd2:    ms = 13'd100;
      3'd3:    ms = 13'd50;
      default: ms = 13'd25;
    endcase
    case (gain)
      3'd0:    d = ms;
      3'd1:    d = 13'(ms * 3);
      3'd2:    d = 13'(ms * 6);
      3'd3:    d = 13'(ms * 9);
      default: d = 13'(ms * 18);
    endcase
    return d;
  endfunction

  // Floor of two to the 32nd divided by the divisor.
  function automatic recip_t lux_recip(input den_t d);
    recip_t r;
    case (d)
      13'd25:   r = 32'd171798691;
      13'd50:   r = 32'd85899345;
      13'd75:   r = 32'd57266230;
      13'd100:  r = 32'd42949672;
      13'd150:  r = 32'd28633115;
      13'd200:  r = 32'd21474836;
      13'd225:  r = 32'd19088743;
      13'd300:  r = 32'd14316557;
      13'd400:  r = 32'd10737418;
      13'd450:  r = 32'd9544371;
      13'd600:  r = 32'd7158278;
      13'd900:  r = 32'd4772185;
      13'd1200: r = 32'd3579139;
      13'd1800: r = 32'd2386092;
      13'd2400: r = 32'd1789569;
      13'd3600: r = 32'd1193046;
      13'd7200: r = 32'd596523;
      default:  r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### src/ambient_light_lux_convert.sv
// ----------------------------------------------------------------------------
// Ambient light lux conversion
// Turns one sensor reading into a status code and an illuminance in lux,
// lux = count * 60 / (gain * conversion_ms), truncated and saturated.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   in        sink       in_valid_i / in_stall_o   read_failed_i, status_byte_i, data_*_i
//   out       source     out_valid_o / out_stall_i result_status_o, lux_o
//   cfg       sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A reading passes from the input stage through the reciprocal multiply, the
// remainder multiply and the correction stage to the result, and one reading
// can be taken every cycle while the output is not stalled. Reset clears all
// stage valid bits and loads the register defaults. A stall holds a full stage
// only when every stage after it is full too; empty stages still fill.
// ----------------------------------------------------------------------------
module ambient_light_lux_convert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [alc_pkg::CodeW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        read_failed_i,
  input  logic [7:0]                  status_byte_i,
  input  logic [7:0]                  data_low_i,
  input  logic [7:0]                  data_mid_i,
  input  logic [7:0]                  data_high_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  result_status_o,
  output logic [alc_pkg::LuxW-1:0]    lux_o
);
  import alc_pkg::*;

  logic [CodeW-1:0] res_q;
  logic [CodeW-1:0] gain_q;
  den_t             den;
  recip_t           recip;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  lux_status_e     st1_q, st2_q, st3_q, st4_q;
  lux_status_e     st1_d;
  logic [NumW-1:0] num1_q, num2_q;
  logic [NumW-1:0] num1_d;
  logic [CountW-1:0] count;
  logic [QuotW-1:0] quot2_q, quot3_q;
  logic [RemW-1:0] rem3_q;
  logic [LuxW-1:0] lux4_q, lux4_d;
  logic [57:0]     prod;
  logic [34:0]     qd;
  logic [NumW-1:0] diff;
  logic [QuotW:0]  quot_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= ResResetCode;
      gain_q <= GainResetCode;
    end else if (cfg_we_i && cfg_wdata_i < NumCodes) begin
      if (cfg_idx_i == REG_RESOLUTION) begin
        res_q <= cfg_wdata_i;
      end else begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  assign den   = lux_den(res_q, gain_q);
  assign recip = lux_recip(den);

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign count  = {data_high_i[3:0], data_mid_i, data_low_i};
  assign num1_d = {count, 6'b0} - {4'b0, count, 2'b0};

  always_comb begin
    if (read_failed_i) begin
      st1_d = ST_BUS_ERR;
    end else if (!status_byte_i[ReadyBit]) begin
      st1_d = ST_NO_DATA;
    end else begin
      st1_d = ST_NEW_LUX;
    end
  end

  assign prod = 58'(num1_q) * 58'(recip);
  assign qd   = 35'(quot2_q) * 35'(den);
  assign diff = num2_q - qd[NumW-1:0];

  assign quot_fix = {1'b0, quot3_q} + (QuotW+1)'(rem3_q >= {1'b0, den});

  always_comb begin
    if (st3_q != ST_NEW_LUX) begin
      lux4_d = '0;
    end else if (quot_fix > (QuotW+1)'({LuxW{1'b1}})) begin
      lux4_d = {LuxW{1'b1}};
    end else begin
      lux4_d = quot_fix[LuxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      st1_q  <= st1_d;
      num1_q <= num1_d;
    end
    if (en2) begin
      st2_q   <= st1_q;
      num2_q  <= num1_q;
      quot2_q <= prod[RecipW+QuotW-1:RecipW];
    end
    if (en3) begin
      st3_q   <= st2_q;
      quot3_q <= quot2_q;
      rem3_q  <= diff[RemW-1:0];
    end
    if (en4) begin
      st4_q  <= st3_q;
      lux4_q <= lux4_d;
    end
  end

  assign out_valid_o     = v4_q;
  assign result_status_o = st4_q;
  assign lux_o           = lux4_q;

endmodule

### src/alc_checker.sv
// ----------------------------------------------------------------------------
// Ambient light lux conversion checker
// Port-level properties of the conversion pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module alc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               result_status_o,
  input logic [alc_pkg::LuxW-1:0] lux_o
);
  import alc_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_status_o == ST_BUS_ERR || result_status_o == ST_NO_DATA ||
                     result_status_o == ST_NEW_LUX))
    else $error("result status outside defined codes");

  a_lux_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_status_o != ST_NEW_LUX) |-> lux_o == '0)
    else $error("lux nonzero without new data");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage is empty");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(lux_o) && $stable(result_status_o)))
    else $error("stalled result changed");

endmodule

bind ambient_light_lux_convert alc_checker u_alc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_status_o (result_status_o),
  .lux_o           (lux_o)
);

### dv/ambient_light_lux_convert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light lux conversion testbench
// Drives sensor readings and register writes into the converter, predicts
// the status and lux of every reading and checks each result transfer in
// order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ambient_light_lux_convert_test;
  import alc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned PhaseItems    = 72;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned MaxReports    = 10;

  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    lux_status_e     status;
    logic [LuxW-1:0] lux;
  } lux_result_t;

  class lux_checker;
    lux_result_t expected_lux[$];
    code_t       res_code  = ResResetCode;
    code_t       gain_code = GainResetCode;
    int unsigned conv_ms_tbl[5] = '{400, 200, 100, 50, 25};
    int unsigned gain_tbl[5]    = '{1, 3, 6, 9, 18};
    int unsigned readings;
    int unsigned new_lux;
    int unsigned saturated;
    int unsigned reg_writes;
    int unsigned mismatches;

    function void write_register(reg_idx_e idx, code_t value);
      reg_writes++;
      if (value >= NumCodes) return;
      if (idx == REG_RESOLUTION) res_code = value;
      else gain_code = value;
    endfunction

    function void note_reading(logic failed, logic [7:0] status, logic [7:0] low,
                               logic [7:0] mid, logic [7:0] high);
      lux_result_t       expected;
      logic [CountW-1:0] count;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   quotient;
      readings++;
      expected.lux = '0;
      if (failed) begin
        expected.status = ST_BUS_ERR;
      end else if (!status[ReadyBit]) begin
        expected.status = ST_NO_DATA;
      end else begin
        expected.status = ST_NEW_LUX;
        new_lux++;
        count = {high[3:0], mid, low};
        num = 64'(count) * 64'd600;
        den = 64'd10 * gain_tbl[gain_code] * conv_ms_tbl[res_code];
        quotient = num / den;
        if (quotient > 64'd65535) begin
          expected.lux = '1;
          saturated++;
        end else begin
          expected.lux = quotient[LuxW-1:0];
        end
      end
      expected_lux.push_back(expected);
    endfunction

    function void flag(string what, logic [1:0] exp_st, logic [LuxW-1:0] exp_lux,
                       logic [1:0] act_st, logic [LuxW-1:0] act_lux);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s: expected status %0d lux %0d, got status %0d lux %0d",
                 $realtime, what, exp_st, exp_lux, act_st, act_lux);
    endfunction

    function void check_result(logic [1:0] status, logic [LuxW-1:0] lux);
      lux_result_t expected;
      if (expected_lux.size() == 0) begin
        flag("unexpected result", 'x, 'x, status, lux);
        return;
      end
      expected = expected_lux.pop_front();
      if (status !== expected.status || lux !== expected.lux)
        flag("result mismatch", expected.status, expected.lux, status, lux);
    endfunction

    function void close();
      while (expected_lux.size() != 0) begin
        flag("missing result", expected_lux[0].status, expected_lux[0].lux, 'x, 'x);
        void'(expected_lux.pop_front());
      end
    endfunction
  endclass

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  reg_idx_e        cfg_idx_i     = REG_RESOLUTION;
  code_t           cfg_wdata_i   = '0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic            read_failed_i = 1'b0;
  logic [7:0]      status_byte_i = '0;
  logic [7:0]      data_low_i    = '0;
  logic [7:0]      data_mid_i    = '0;
  logic [7:0]      data_high_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [1:0]      result_status_o;
  logic [LuxW-1:0] lux_o;

  lux_checker  lux_chk = new;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  ambient_light_lux_convert i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .read_failed_i,
    .status_byte_i,
    .data_low_i,
    .data_mid_i,
    .data_high_i,
    .out_valid_o,
    .out_stall_i,
    .result_status_o,
    .lux_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) lux_chk.check_result(result_status_o, lux_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
      $display("ambient_light_lux_convert_test: FAIL");
      $finish;
    end
  end

  task automatic send_reading(logic failed, logic [7:0] status, logic [7:0] low,
                              logic [7:0] mid, logic [7:0] high);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    read_failed_i <= failed;
    status_byte_i <= status;
    data_low_i    <= low;
    data_mid_i    <= mid;
    data_high_i   <= high;
    do @(posedge clk_i); while (in_stall_o);
    lux_chk.note_reading(failed, status, low, mid, high);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (lux_chk.expected_lux.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_code(reg_idx_e idx, code_t value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lux_chk.write_register(idx, value);
  endtask

  initial begin
    logic       failed;
    logic [7:0] status;
    logic [7:0] low;
    logic [7:0] mid;
    logic [7:0] high;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: bus errors, missing data, zero and full-scale counts.
    send_reading(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_reading(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_reading(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_reading(1'b0, 8'hF7, 8'h12, 8'h34, 8'h05);
    send_reading(1'b0, 8'h08, 8'h00, 8'h00, 8'h00);
    send_reading(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_reading(1'b0, 8'h08, 8'h00, 8'h00, 8'hF0);
    send_reading(1'b0, 8'h08, 8'h78, 8'h00, 8'h00);
    send_reading(1'b0, 8'h08, 8'h77, 8'h00, 8'h00);

    // Smallest divisor: the edge of saturation.
    write_code(REG_RESOLUTION, code_t'(NumCodes - 1));
    write_code(REG_GAIN, '0);
    send_reading(1'b0, 8'h08, 8'hAA, 8'h6A, 8'h00);
    send_reading(1'b0, 8'h08, 8'hAB, 8'h6A, 8'h00);
    send_reading(1'b0, 8'h08, 8'hFF, 8'hFF, 8'h0F);
    send_reading(1'b0, 8'h08, 8'h01, 8'h00, 8'h00);

    // Unsupported codes must leave both registers unchanged.
    write_code(REG_RESOLUTION, code_t'(NumCodes + 2));
    write_code(REG_GAIN, NumCodes);
    send_reading(1'b0, 8'h08, 8'hAB, 8'h6A, 8'h00);
    send_reading(1'b1, 8'h08, 8'hAB, 8'h6A, 8'h00);

    write_code(REG_RESOLUTION, '0);
    send_reading(1'b0, 8'h08, 8'hFF, 8'hFF, 8'hFF);
    send_reading(1'b0, 8'h08, 8'h00, 8'h00, 8'h01);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p / 3)
        0: begin
          send_idle_pct  = 6;
          recv_stall_pct = 84;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 6;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if ($urandom_range(1))
        write_code(reg_idx_e'($urandom_range(1)), code_t'(NumCodes + $urandom_range(2)));
      case (p)
        0: begin
          write_code(REG_RESOLUTION, '0);
          write_code(REG_GAIN, '0);
        end
        1: begin
          write_code(REG_RESOLUTION, code_t'(NumCodes - 1));
          write_code(REG_GAIN, code_t'(NumCodes - 1));
        end
        2: begin
          write_code(REG_RESOLUTION, code_t'(NumCodes - 1));
          write_code(REG_GAIN, '0);
        end
        3: begin
          write_code(REG_RESOLUTION, '0);
          write_code(REG_GAIN, code_t'(NumCodes - 1));
        end
        default: begin
          write_code(REG_RESOLUTION, code_t'($urandom_range(NumCodes - 1)));
          write_code(REG_GAIN, code_t'($urandom_range(NumCodes - 1)));
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        failed = ($urandom_range(99) < 10);
        status = 8'($urandom_range(255));
        status[ReadyBit] = ($urandom_range(99) < 80);
        low  = 8'($urandom_range(255));
        mid  = 8'($urandom_range(255));
        high = 8'($urandom_range(255));
        case ($urandom_range(3))
          0: begin
            high[3:0] = '0;
            mid       = 8'($urandom_range(3));
          end
          1: high[3:0] = '0;
          default: ;
        endcase
        send_reading(failed, status, low, mid, high);
      end
    end

    drain();
    lux_chk.close();
    $display("Checked %0d readings over %0d register writes and several idle patterns.",
             lux_chk.readings, lux_chk.reg_writes);
    $display("Of these, %0d carried new data and %0d of those saturated.",
             lux_chk.new_lux, lux_chk.saturated);
    if (lux_chk.mismatches == 0) begin
      $display("ambient_light_lux_convert_test: PASS");
    end else begin
      $display("%0d mismatches.", lux_chk.mismatches);
      $display("ambient_light_lux_convert_test: FAIL");
    end
    $finish;
  end

endmodule
